/* src/lcmdiv_pkg.sv */
// Package with the widths and sequencer state codes of the set multiple unit.
`timescale 1ns / 1ps
package lcmdiv_pkg;
  localparam int VALUE_W     = 16;
  localparam int MAX_MEMBERS = 16;
  localparam int MEM_AW      = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int PROD_W      = 32;
  localparam int MUL_W       = PROD_W + VALUE_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef logic [2:0] state_t;

  localparam state_t S_LOAD  = 3'd0;
  localparam state_t S_RD    = 3'd1;
  localparam state_t S_RDW   = 3'd2;
  localparam state_t S_GSTEP = 3'd3;
  localparam state_t S_DIV   = 3'd4;
  localparam state_t S_MUL   = 3'd5;
  localparam state_t S_ACC   = 3'd6;
  localparam state_t S_DONE  = 3'd7;
endpackage

/* src/lcmdiv_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lcmdiv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* src/lcm_of_set_by_division_unit.sv */
// Sequencing: members load at one word per cycle while in_tready is high; after the last word
// each stored member runs its Euclid steps and a division by the gcd, all on one shared
// 32-step restoring divider. A set holding a zero, or a saturated product, ends early.
// Throughput: one set at a time; no input is taken from the last member until the result
// is in the output register, which may still be waiting while the next set loads.
// Reset: synchronous active-low rst_n clears the sequencer, the counts and the output valid.
`timescale 1ns / 1ps
module lcm_of_set_by_division_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] multiple
  output logic        out_tuser   // [0] overflow
);
  localparam int VW = lcmdiv_pkg::VALUE_W;
  localparam int PW = lcmdiv_pkg::PROD_W;
  localparam int MW = lcmdiv_pkg::MUL_W;
  localparam int AW = lcmdiv_pkg::MEM_AW;
  localparam int CW = lcmdiv_pkg::CNT_W;
  localparam int SW = lcmdiv_pkg::STEP_W;

  lcmdiv_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          zero_r, zero_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [VW-1:0] member_r, member_nxt;
  logic [PW-1:0] a_r, a_nxt;
  logic [VW-1:0] b_r, b_nxt;
  logic          quot_r, quot_nxt;
  logic [PW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [MW-1:0] prod_r, prod_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_data_r, out_data_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          in_fire;
  logic          store_ok;
  logic          zero_now;
  logic [VW-1:0] rd_data;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;
  logic          last_member;
  logic          out_free;

  assign in_tready   = (state_r == lcmdiv_pkg::S_LOAD);
  assign in_fire     = in_tvalid && in_tready;
  assign store_ok    = (count_r < CW'(lcmdiv_pkg::MAX_MEMBERS));
  assign zero_now    = zero_r || (store_ok && (in_tdata == '0));
  assign trial       = {rem_r, quo_r[PW-1]};
  assign diff        = trial - {1'b0, dvs_r};
  assign fits        = (trial >= {1'b0, dvs_r});
  assign last_member = ((CW'(idx_r) + CW'(1)) == count_r);
  assign out_free    = !out_valid_r || out_tready;

  lcmdiv_ram #(
    .WIDTH(VW),
    .DEPTH(lcmdiv_pkg::MAX_MEMBERS)
  ) u_store (
    .clk  (clk),
    .we   (in_fire && store_ok),
    .waddr(count_r[AW-1:0]),
    .wdata(in_tdata),
    .raddr(idx_r),
    .rdata(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    zero_nxt      = zero_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    member_nxt    = member_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    quot_nxt      = quot_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      lcmdiv_pkg::S_LOAD: begin
        if (in_fire) begin
          if (store_ok) begin
            count_nxt = count_r + CW'(1);
          end
          zero_nxt = zero_now;
          if (in_tlast) begin
            idx_nxt = '0;
            ovf_nxt = 1'b0;
            if (zero_now) begin
              acc_nxt   = '0;
              state_nxt = lcmdiv_pkg::S_DONE;
            end else begin
              acc_nxt   = PW'(1);
              state_nxt = lcmdiv_pkg::S_RD;
            end
          end
        end
      end
      lcmdiv_pkg::S_RD: begin
        state_nxt = lcmdiv_pkg::S_RDW;
      end
      lcmdiv_pkg::S_RDW: begin
        member_nxt = rd_data;
        a_nxt      = acc_r;
        b_nxt      = rd_data;
        state_nxt  = lcmdiv_pkg::S_GSTEP;
      end
      lcmdiv_pkg::S_GSTEP: begin
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = lcmdiv_pkg::S_DIV;
        if (b_r == '0) begin
          quot_nxt = 1'b1;
          quo_nxt  = PW'(member_r);
          dvs_nxt  = a_r[VW-1:0];
        end else begin
          quot_nxt = 1'b0;
          quo_nxt  = a_r;
          dvs_nxt  = b_r;
        end
      end
      lcmdiv_pkg::S_DIV: begin
        quo_nxt  = {quo_r[PW-2:0], fits};
        rem_nxt  = fits ? diff[VW-1:0] : trial[VW-1:0];
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(lcmdiv_pkg::DIV_STEPS - 1)) begin
          if (quot_r) begin
            state_nxt = lcmdiv_pkg::S_MUL;
          end else begin
            a_nxt     = PW'(b_r);
            b_nxt     = fits ? diff[VW-1:0] : trial[VW-1:0];
            state_nxt = lcmdiv_pkg::S_GSTEP;
          end
        end
      end
      lcmdiv_pkg::S_MUL: begin
        prod_nxt  = MW'(acc_r) * MW'(quo_r[VW-1:0]);
        state_nxt = lcmdiv_pkg::S_ACC;
      end
      lcmdiv_pkg::S_ACC: begin
        if (prod_r[MW-1:PW] != '0) begin
          acc_nxt   = '1;
          ovf_nxt   = 1'b1;
          state_nxt = lcmdiv_pkg::S_DONE;
        end else begin
          acc_nxt = prod_r[PW-1:0];
          if (last_member) begin
            state_nxt = lcmdiv_pkg::S_DONE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = lcmdiv_pkg::S_RD;
          end
        end
      end
      lcmdiv_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          zero_nxt      = 1'b0;
          state_nxt     = lcmdiv_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = lcmdiv_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcmdiv_pkg::S_LOAD;
      count_r     <= '0;
      zero_r      <= 1'b0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      quot_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      zero_r      <= zero_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      quot_r      <= quot_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    member_r   <= member_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

`ifndef SYNTHESIS
  // A saturated word always carries the all-ones multiple.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '1)
    else $error("overflow word without saturated multiple");

  // The shared divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcmdiv_pkg::S_DIV |-> dvs_r != '0)
    else $error("divider started with zero divisor");

  // The member count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(lcmdiv_pkg::MAX_MEMBERS))
    else $error("member count beyond store depth");

  // The word that closes a set stops the input side.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken after closing word");
`endif
endmodule

/* bench/testbench.sv */
// Self-checking bench for the set multiple unit: random and directed sets against a predictor.
`timescale 1ns / 1ps
module testbench;
  localparam int ITEM_TARGET = 2000;
  localparam int LONG_HOLD   = 3000;
  localparam int IDLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [lcmdiv_pkg::PROD_W-1:0] multiple;
    logic                          overflow;
  } set_result_t;

  class set_multiple_board;
    logic [lcmdiv_pkg::VALUE_W-1:0] members[$];
    bit                             zero_seen;
    set_result_t                    expected_results[$];
    int unsigned                    errors;

    function int pending();
      return expected_results.size();
    endfunction

    // Members past the store depth are dropped, zeros included.
    function void add_member(logic [lcmdiv_pkg::VALUE_W-1:0] v, logic l);
      logic [63:0] lcm_acc;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      set_result_t r;
      if (members.size() < lcmdiv_pkg::MAX_MEMBERS) begin
        members.push_back(v);
        if (v == '0) zero_seen = 1'b1;
      end
      if (l) begin
        r.multiple = '0;
        r.overflow = 1'b0;
        if (!zero_seen) begin
          lcm_acc = 64'd1;
          for (int i = 0; i < members.size() && !r.overflow; i++) begin
            a = lcm_acc;
            b = 64'(members[i]);
            while (b != 0) begin
              t = a % b;
              a = b;
              b = t;
            end
            lcm_acc = lcm_acc / a * 64'(members[i]);
            if (lcm_acc > 64'hFFFF_FFFF) r.overflow = 1'b1;
          end
          r.multiple = r.overflow ? '1 : lcm_acc[lcmdiv_pkg::PROD_W-1:0];
        end
        expected_results.push_back(r);
        members.delete();
        zero_seen = 1'b0;
      end
    endfunction

    function void check_result(logic [lcmdiv_pkg::PROD_W-1:0] m, logic ov);
      set_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got multiple %0d overflow %0b",
                 $time, m, ov);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (m !== e.multiple) begin
        $display("%0t: multiple mismatch, expected %0d, got %0d", $time, e.multiple, m);
        errors++;
      end
      if (ov !== e.overflow) begin
        $display("%0t: overflow mismatch, expected %0b, got %0b", $time, e.overflow, ov);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  set_multiple_board board = new();
  int unsigned       items_sent;
  int unsigned       idle_cycles;
  bit                quiet;
  bit                hold_request;

  lcm_of_set_by_division_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.add_member(in_tdata, in_tlast);
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_member(input logic [15:0] v, input logic l);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic wait_for_results();
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r <= 8) return 16'($urandom_range(1, 63));
    if (r <= 14) return 16'($urandom);
    return 16'($urandom_range(1, 255) * $urandom_range(1, 255));
  endfunction

  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 2);
    if (r < 80) return $urandom_range(3, 5);
    if (r < 95) return $urandom_range(6, lcmdiv_pkg::MAX_MEMBERS);
    return $urandom_range(lcmdiv_pkg::MAX_MEMBERS + 1, lcmdiv_pkg::MAX_MEMBERS + 4);
  endfunction

  initial begin
    int  set_len;
    bit  hold_done;
    bit  pause_done;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_request = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_member(16'hFFFF, 1'b1);
    send_member(16'd0, 1'b1);
    send_member(16'd1, 1'b1);
    send_member(16'd12, 1'b0);
    send_member(16'd18, 1'b0);
    send_member(16'd8, 1'b1);
    send_member(16'd65521, 1'b0);
    send_member(16'd65519, 1'b0);
    send_member(16'd65497, 1'b1);
    // A full store followed by a zero that must be dropped.
    repeat (lcmdiv_pkg::MAX_MEMBERS) send_member(16'd3, 1'b0);
    send_member(16'd0, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 600) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && items_sent >= 1200) begin
        in_tvalid <= 1'b0;
        wait_for_results();
        pause_done = 1'b1;
      end
      if (items_sent >= ITEM_TARGET * 17 / 20) quiet = 1'b1;
      set_len = pick_set_size();
      for (int i = 0; i < set_len; i++) begin
        send_member(pick_value(), i == set_len - 1);
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_tvalid <= 1'b0;
          in_tdata  <= 16'($urandom);
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
